@@ hw/rtl/png_chunk_idat_row_extractor_defines.svh @@
// Assertion macros for the RTL of the PNG IDAT row extractor.
// Each macro expects the enclosing module to have clk and rst_n.
`ifndef PNG_CHUNK_IDAT_ROW_EXTRACTOR_DEFINES_SVH
`define PNG_CHUNK_IDAT_ROW_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define PNGIDAT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PNGIDAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PNGIDAT_ASSERT_SAME(label, ante, cons)
`define PNGIDAT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hw/rtl/pngidat_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pngidat_pkg;

  localparam int FILE_BYTE_W = 8;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int ADDR_W      = 26;
  localparam int TDATA_OUT_W = 40;
  localparam int PAD_W       = TDATA_OUT_W - FILE_BYTE_W - ADDR_W;

  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;

  typedef logic [FILE_BYTE_W-1:0] byte_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [ADDR_W-1:0]      addr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'd0,
    REG_HEIGHT = 1'd1
  } cfg_reg_t;

  typedef enum logic [5:0] {
    PH_SIG     = 6'b000001,
    PH_LEN     = 6'b000010,
    PH_TYPE    = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CRC     = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic valid;
    logic is_end;
  } s1_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/pngidat_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pngidat_parser #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int BW = WW + 2,
  localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_fire,
  input  wire pngidat_pkg::byte_t      in_byte,
  input  wire logic                    s1_load,
  input  wire logic                    cfg_fire,
  input  wire pngidat_pkg::cfg_idx_t   cfg_idx,
  input  wire pngidat_pkg::cfg_data_t  cfg_val,
  output pngidat_pkg::s1_ctl_t         s1_ctl,
  output pngidat_pkg::byte_t           s1_pix,
  output logic [RW-1:0]                s1_roff,
  output logic [BW-1:0]                s1_col,
  output logic [BW-1:0]                s1_rb
);
  import pngidat_pkg::*;

  phase_t         phase_r, phase_nxt;
  logic [2:0]     cnt_r, cnt_nxt;
  logic [31:0]    len_r, len_nxt;
  logic [23:0]    type_r, type_nxt;
  logic           idat_r, idat_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [BW-1:0]  pos_r, pos_nxt;
  logic [BW-1:0]  rb_r, rb_nxt;
  logic [RW-1:0]  h_r, h_nxt;

  s1_ctl_t        s1_ctl_r;
  byte_t          s1_pix_r;
  logic [RW-1:0]  s1_roff_r;
  logic [BW-1:0]  s1_col_r;
  logic [BW-1:0]  s1_rb_r;

  logic           wrap;
  logic [BW-1:0]  pos1;
  logic [RW:0]    row1;
  logic           idat_drop, idat_filter, idat_emit, row_end;
  logic [RW-1:0]  idat_row, idat_roff;
  logic [BW-1:0]  idat_pos, idat_col;
  logic [31:0]    tword;
  logic           res_emit, res_end;
  logic [WW-1:0]  w_clamp;

  always_comb begin
    if (cfg_val == '0) begin
      w_clamp = WW'(1);
    end else if (32'(cfg_val) > MAX_WIDTH) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(cfg_val);
    end
    rb_nxt = rb_r;
    h_nxt  = h_r;
    if (cfg_fire) begin
      unique case (cfg_idx)
        REG_WIDTH:  rb_nxt = {w_clamp, 2'b00};
        REG_HEIGHT: begin
          if (cfg_val == '0) begin
            h_nxt = RW'(1);
          end else if (32'(cfg_val) > MAX_HEIGHT) begin
            h_nxt = RW'(MAX_HEIGHT);
          end else begin
            h_nxt = RW'(cfg_val);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    wrap        = pos_r > rb_r;
    pos1        = wrap ? '0 : pos_r;
    row1        = wrap ? {1'b0, row_r} + 1'b1 : {1'b0, row_r};
    idat_drop   = row1 >= {1'b0, h_r};
    idat_filter = !idat_drop && (pos1 == '0);
    idat_emit   = !idat_drop && !idat_filter;
    row_end     = pos1 >= rb_r;
    idat_col    = pos1 - 1'b1;
    idat_roff   = RW'({1'b0, h_r} - row1 - 1'b1);
    if (idat_drop) begin
      idat_row = h_r;
      idat_pos = pos1;
    end else if (idat_filter) begin
      idat_row = RW'(row1);
      idat_pos = BW'(1);
    end else if (row_end) begin
      idat_row = RW'(row1 + 1'b1);
      idat_pos = '0;
    end else begin
      idat_row = RW'(row1);
      idat_pos = pos1 + 1'b1;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    idat_nxt  = idat_r;
    row_nxt   = row_r;
    pos_nxt   = pos_r;
    res_emit  = 1'b0;
    res_end   = 1'b0;
    tword     = {type_r, in_byte};
    if (in_fire) begin
      unique case (phase_r)
        PH_SIG: begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == 3'd7) begin
            cnt_nxt   = '0;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          len_nxt = {len_r[23:0], in_byte};
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == 3'd3) begin
            cnt_nxt   = '0;
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_nxt = tword[23:0];
          cnt_nxt  = cnt_r + 1'b1;
          if (cnt_r == 3'd3) begin
            cnt_nxt = '0;
            if (tword == TYPE_IEND) begin
              phase_nxt = PH_DONE;
              res_end   = 1'b1;
            end else begin
              idat_nxt  = tword == TYPE_IDAT;
              phase_nxt = (len_r == '0) ? PH_CRC : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (idat_r) begin
            row_nxt  = idat_row;
            pos_nxt  = idat_pos;
            res_emit = idat_emit;
          end
          len_nxt = len_r - 1'b1;
          if (len_r == 32'd1) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == 3'd3) begin
            cnt_nxt   = '0;
            idat_nxt  = 1'b0;
            phase_nxt = PH_LEN;
          end
        end
        PH_DONE: ;
        default: phase_nxt = PH_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIG;
      cnt_r    <= '0;
      len_r    <= '0;
      type_r   <= '0;
      idat_r   <= 1'b0;
      row_r    <= '0;
      pos_r    <= '0;
      rb_r     <= BW'(4);
      h_r      <= RW'(1);
      s1_ctl_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      idat_r  <= idat_nxt;
      row_r   <= row_nxt;
      pos_r   <= pos_nxt;
      rb_r    <= rb_nxt;
      h_r     <= h_nxt;
      if (s1_load) begin
        s1_ctl_r.valid  <= res_emit || res_end;
        s1_ctl_r.is_end <= res_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pix_r  <= res_end ? '0 : in_byte;
      s1_roff_r <= res_end ? '0 : idat_roff;
      s1_col_r  <= res_end ? '0 : idat_col;
      s1_rb_r   <= rb_r;
    end
  end

  assign s1_ctl  = s1_ctl_r;
  assign s1_pix  = s1_pix_r;
  assign s1_roff = s1_roff_r;
  assign s1_col  = s1_col_r;
  assign s1_rb   = s1_rb_r;

endmodule

`default_nettype wire

@@ hw/rtl/pngidat_addr.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pngidat_addr #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int BW = WW + 2,
  localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pngidat_pkg::s1_ctl_t s1_ctl,
  input  wire pngidat_pkg::byte_t   s1_pix,
  input  wire logic [RW-1:0]        s1_roff,
  input  wire logic [BW-1:0]        s1_col,
  input  wire logic [BW-1:0]        s1_rb,
  output logic                      s2_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_end,
  output pngidat_pkg::byte_t        out_pix,
  output pngidat_pkg::addr_t        out_addr
);
  import pngidat_pkg::*;

  logic [RW+BW-1:0] prod;
  logic [RW+BW:0]   sum;
  logic             valid_r;
  logic             end_r;
  byte_t            pix_r;
  addr_t            addr_r;

  assign s2_ready = !valid_r || out_ready;
  assign prod     = s1_roff * s1_rb;
  assign sum      = {1'b0, prod} + (RW + BW + 1)'(s1_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s2_ready) begin
      valid_r <= s1_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_ctl.valid) begin
      end_r  <= s1_ctl.is_end;
      pix_r  <= s1_pix;
      addr_r <= ADDR_W'(sum);
    end
  end

  assign out_valid = valid_r;
  assign out_end   = end_r;
  assign out_pix   = pix_r;
  assign out_addr  = addr_r;

endmodule

`default_nettype wire

@@ hw/rtl/png_chunk_idat_row_extractor.sv @@
// PNG chunk deframer that pulls raw RGBA scanlines out of IDAT chunks.
// The in_ channel takes one file byte per word. The out_ channel gives one
// word per pixel byte, with the pixel in tdata[7:0] and its frame buffer
// byte address in tdata[33:8]; rows are stored bottom to top. A word with
// tuser and tlast high marks the IEND chunk; after it all input is taken
// and dropped. The cfg_ channel sets the image width (index 0) and height
// (index 1); it is always ready and should be written only while idle.
// Throughput is one byte per cycle while the receiver keeps up. The edge that
// takes an input byte loads the parser result, and the output register then
// takes the row times row-length multiply and shows the word on out_tvalid.
// Bytes that yield no word leave a bubble and do not hold up the input. When the
// receiver stalls, the output register holds its word and the middle stage
// still fills, so in_tready drops only when both are full. Synchronous reset
// returns the parser to the signature, clears the row position and sets
// width and height to one.
`timescale 1ns / 1ps
`default_nettype none
`include "png_chunk_idat_row_extractor_defines.svh"

module png_chunk_idat_row_extractor #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [7:0]                           in_tdata,   // file_byte
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [pngidat_pkg::TDATA_OUT_W-1:0]       out_tdata,  // pixel_value, buffer_address
  output logic                                      out_tuser,  // result_kind
  output logic                                      out_tlast,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire pngidat_pkg::cfg_idx_t                cfg_index,
  input  wire pngidat_pkg::cfg_data_t               cfg_data
);
  import pngidat_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int BW = WW + 2;
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  s1_ctl_t       s1_ctl;
  byte_t         s1_pix;
  logic [RW-1:0] s1_roff;
  logic [BW-1:0] s1_col;
  logic [BW-1:0] s1_rb;
  logic          s2_ready;
  logic          s1_load;
  logic          in_fire;
  logic          out_end;
  byte_t         out_pix;
  addr_t         out_addr;

  assign s1_load   = !s1_ctl.valid || s2_ready;
  assign in_tready = s1_load;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  pngidat_parser #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_byte  (in_tdata),
    .s1_load  (s1_load),
    .cfg_fire (cfg_valid && cfg_ready),
    .cfg_idx  (cfg_index),
    .cfg_val  (cfg_data),
    .s1_ctl   (s1_ctl),
    .s1_pix   (s1_pix),
    .s1_roff  (s1_roff),
    .s1_col   (s1_col),
    .s1_rb    (s1_rb)
  );

  pngidat_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_ctl    (s1_ctl),
    .s1_pix    (s1_pix),
    .s1_roff   (s1_roff),
    .s1_col    (s1_col),
    .s1_rb     (s1_rb),
    .s2_ready  (s2_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_end   (out_end),
    .out_pix   (out_pix),
    .out_addr  (out_addr)
  );

  assign out_tdata = {{PAD_W{1'b0}}, out_addr, out_pix};
  assign out_tuser = out_end;
  assign out_tlast = out_end;

  `PNGIDAT_ASSERT_SAME(a_end_word_zero, out_tvalid && out_tlast, out_tdata == '0)
  `PNGIDAT_ASSERT_NEXT(a_nothing_after_end, out_tvalid && out_tready && out_tlast, !out_tvalid)
  `PNGIDAT_ASSERT_SAME(a_ready_when_out_free, !out_tvalid, in_tready)

endmodule

`default_nettype wire

@@ tb/sv/png_pixel_checker.sv @@
`timescale 1ns / 1ps

module png_pixel_checker
  import pngidat_pkg::*;
#(
  parameter int MAX_W = 4096,
  parameter int MAX_H = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  byte_t                  in_tdata,    // file_byte
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [TDATA_OUT_W-1:0] out_tdata,   // pixel_value, buffer_address, zero pad
  input  logic                   out_tuser,   // result_kind
  input  logic                   out_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  cfg_idx_t               cfg_index,
  input  cfg_data_t              cfg_data,
  output int                     fail_count,
  output int                     words_due,
  output int                     words_checked
);

  localparam int unsigned BYTES_PER_PIXEL = 4;
  localparam int          MAX_REPORTS     = 20;

  typedef struct packed {
    logic  is_end;
    byte_t pixel;
    addr_t addr;
    logic  last;
  } fb_word_t;

  cfg_data_t   width_reg;
  cfg_data_t   height_reg;
  phase_t      phase;
  int unsigned field_cnt;
  logic [31:0] chunk_len;
  logic [31:0] payload_left;
  logic [31:0] type_acc;
  logic        in_idat;
  logic        file_done;
  int unsigned row_idx;
  int unsigned row_pos;
  int          errors;
  int          checked;
  fb_word_t    fb_words_due[$];

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
    if (v < 1) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // Places one IDAT payload byte in the flipped frame buffer.
  function automatic bit place_idat_byte(input byte_t b, output fb_word_t w);
    int unsigned w_px;
    int unsigned h_rows;
    int unsigned row_len;
    int unsigned col;
    w_px    = clamp_dim(width_reg, MAX_W);
    h_rows  = clamp_dim(height_reg, MAX_H);
    row_len = w_px * BYTES_PER_PIXEL;
    w       = '0;
    if (row_pos != 0 && row_pos - 1 >= row_len) begin
      row_pos = 0;
      row_idx++;
    end
    if (row_idx >= h_rows) begin
      row_idx = h_rows;
      return 0;
    end
    if (row_pos == 0) begin
      row_pos = 1;
      return 0;
    end
    col     = row_pos - 1;
    w.pixel = b;
    w.addr  = addr_t'((h_rows - 1 - row_idx) * row_len + col);
    if (col + 1 >= row_len) begin
      row_pos = 0;
      row_idx++;
    end else begin
      row_pos++;
    end
    return 1;
  endfunction

  function automatic bit parse_file_byte(input byte_t b, output fb_word_t w);
    bit hit;
    hit = 0;
    w   = '0;
    if (file_done) return 0;
    case (phase)
      PH_SIG: begin
        field_cnt++;
        if (field_cnt >= 8) begin
          field_cnt = 0;
          phase     = PH_LEN;
        end
      end
      PH_LEN: begin
        chunk_len = {chunk_len[23:0], b};
        field_cnt++;
        if (field_cnt >= 4) begin
          field_cnt = 0;
          type_acc  = '0;
          phase     = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_acc = {type_acc[23:0], b};
        field_cnt++;
        if (field_cnt >= 4) begin
          field_cnt = 0;
          if (type_acc == TYPE_IEND) begin
            file_done = 1'b1;
            phase     = PH_DONE;
            w.is_end  = 1'b1;
            w.last    = 1'b1;
            hit       = 1;
          end else begin
            in_idat      = (type_acc == TYPE_IDAT);
            payload_left = chunk_len;
            phase        = (payload_left == 0) ? PH_CRC : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (in_idat) hit = place_idat_byte(b, w);
        payload_left--;
        if (payload_left == 0) phase = PH_CRC;
      end
      PH_CRC: begin
        field_cnt++;
        if (field_cnt >= 4) begin
          field_cnt = 0;
          chunk_len = '0;
          in_idat   = 1'b0;
          phase     = PH_LEN;
        end
      end
      default: begin
        file_done = 1'b1;
        phase     = PH_DONE;
      end
    endcase
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < MAX_REPORTS) begin
      $display("mismatch at %0t ns: %s is 0x%0h, predicted 0x%0h", $time, what, got, want);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    fb_word_t want;
    fb_word_t next_word;
    if (!rst_n) begin
      width_reg    = 1;
      height_reg   = 1;
      phase        = PH_SIG;
      field_cnt    = 0;
      chunk_len    = '0;
      payload_left = '0;
      type_acc     = '0;
      in_idat      = 1'b0;
      file_done    = 1'b0;
      row_idx      = 0;
      row_pos      = 0;
      errors       = 0;
      checked      = 0;
      fb_words_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (fb_words_due.size() == 0) begin
          report_mismatch("word with nothing predicted, tdata", longint'(out_tdata), 0);
        end else begin
          want = fb_words_due.pop_front();
          checked++;
          if (out_tuser !== want.is_end)
            report_mismatch("result kind", out_tuser, want.is_end);
          if (out_tdata[FILE_BYTE_W-1:0] !== want.pixel)
            report_mismatch("pixel value", out_tdata[FILE_BYTE_W-1:0], want.pixel);
          if (out_tdata[FILE_BYTE_W +: ADDR_W] !== want.addr)
            report_mismatch("buffer address", out_tdata[FILE_BYTE_W +: ADDR_W], want.addr);
          if (out_tlast !== want.last)
            report_mismatch("last flag", out_tlast, want.last);
          if (out_tdata[TDATA_OUT_W-1 -: PAD_W] !== '0)
            report_mismatch("tdata padding", out_tdata[TDATA_OUT_W-1 -: PAD_W], 0);
        end
      end
      if (in_tvalid && in_tready) begin
        if (parse_file_byte(in_tdata, next_word)) fb_words_due.push_back(next_word);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_HEIGHT) height_reg = cfg_data;
      end
    end
    fail_count    <= errors;
    words_due     <= fb_words_due.size();
    words_checked <= checked;
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import pngidat_pkg::*;

  localparam int MAX_W         = 4096;
  localparam int MAX_H         = 4096;
  localparam int FILE_BYTES    = 1800;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;

  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  byte_t                  in_tdata   = '0;    // file_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] out_tdata;          // pixel_value, buffer_address, zero pad
  logic                   out_tuser;          // result_kind
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index  = REG_WIDTH;
  cfg_data_t              cfg_data   = '0;

  int       fail_count;
  int       words_due;
  int       words_checked;
  int       cycles     = 0;
  int       dim_writes = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode    = RX_FREE;
  int       rx_left    = 0;
  byte_t    file_q[$];

  png_chunk_idat_row_extractor #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  png_pixel_checker #(
    .MAX_W(MAX_W),
    .MAX_H(MAX_H)
  ) pixel_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .words_due    (words_due),
    .words_checked(words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= $urandom_range(0, 1);
      RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  function automatic void push_word32(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) file_q.push_back(v[i*8 +: 8]);
  endfunction

  function automatic void add_chunk(input logic [31:0] chunk_type, input int len);
    push_word32(len);
    push_word32(chunk_type);
    repeat (len) file_q.push_back(byte_t'($urandom));
    repeat (4) file_q.push_back(byte_t'($urandom));
  endfunction

  task automatic write_dims(input cfg_data_t w, input cfg_data_t h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    dim_writes += 2;
  endtask

  task automatic send_bytes(input int first, input int count);
    int gap;
    for (int i = first; i < first + count; i++) begin
      in_tvalid <= 1'b1;
      in_tdata  <= file_q[i];
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(40, 150);
          gap        = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap        = $urandom_range(0, 6);
        end
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    repeat (2) @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          next_byte;
    int          count;
    int          phase_no;
    int          pick;
    logic [31:0] code;
    cfg_data_t   w_set;
    cfg_data_t   h_set;

    // Signature, then one short IDAT chunk whose row carries the byte extremes.
    push_word32(32'h8950_4E47);
    push_word32(32'h0D0A_1A0A);
    push_word32(5);
    push_word32(TYPE_IDAT);
    file_q.push_back(8'hFF);
    file_q.push_back(8'h00);
    file_q.push_back(8'hFF);
    file_q.push_back(8'h80);
    file_q.push_back(8'h7F);
    repeat (4) file_q.push_back(byte_t'($urandom));

    while (file_q.size() < FILE_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        add_chunk(TYPE_IDAT, $urandom_range(1, 48));
      end else if (pick < 75) begin
        code = $urandom;
        if (code == TYPE_IEND) code = code ^ 32'h1;
        add_chunk(code, ($urandom_range(0, 15) == 0) ? $urandom_range(200, 300)
                                                     : $urandom_range(0, 32));
      end else if (pick < 85) begin
        add_chunk((pick % 2 == 0) ? TYPE_IDAT : (TYPE_IDAT ^ 32'h20), 0);
      end else begin
        // Types one bit away from the two that the parser acts on.
        code = ((pick % 2 == 0) ? TYPE_IEND : TYPE_IDAT) ^ (32'h1 << $urandom_range(0, 31));
        add_chunk(code, $urandom_range(0, 16));
      end
    end
    // The end chunk; its CRC bytes and the twelve bytes after them are trailing input that must be ignored.
    add_chunk(TYPE_IEND, 0);
    repeat (12) file_q.push_back(byte_t'($urandom));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    next_byte = 0;
    phase_no  = 0;
    while (next_byte < file_q.size()) begin
      case (phase_no)
        0: begin
          w_set = 1;
          h_set = 4096;
        end
        1: begin
          w_set = 8191;
          h_set = 8191;
        end
        2: begin
          w_set = 0;
          h_set = 0;
        end
        3: begin
          w_set = 2;
          h_set = 300;
        end
        default: begin
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            w_set = 4096;
            h_set = $urandom_range(1, 4096);
          end else if (pick == 1) begin
            w_set = $urandom_range(1, 12);
            h_set = 1;
          end else if (pick == 2) begin
            w_set = $urandom_range(4097, 8191);
            h_set = $urandom_range(4097, 8191);
          end else begin
            w_set = $urandom_range(1, 12);
            h_set = $urandom_range(200, 4096);
          end
        end
      endcase
      write_dims(w_set, h_set);
      case (phase_no)
        0:       count = 25;
        1:       count = 60;
        2:       count = 40;
        default: count = $urandom_range(120, 260);
      endcase
      if (next_byte + count + 60 > file_q.size()) count = file_q.size() - next_byte;
      send_bytes(next_byte, count);
      next_byte += count;
      phase_no++;
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d file bytes under %0d image size settings (%0d register writes);",
             file_q.size(), phase_no, dim_writes);
    $display("%0d output words were compared with the predicted frame buffer writes.",
             words_checked);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/pngidat_pkg.sv
hw/rtl/pngidat_parser.sv
hw/rtl/pngidat_addr.sv
hw/rtl/png_chunk_idat_row_extractor.sv
tb/sv/png_pixel_checker.sv
tb/sv/testbench.sv
